FILE: sv/scbor_pkg.sv
// Shared types and constants for the strict CBOR stream parser.
// No dependencies.
`timescale 1ns / 1ps
package scbor_pkg;

   localparam int MaxDepth = 16;
   localparam int DepthW = $clog2(MaxDepth + 1);
   localparam int LevelW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

   localparam logic [1:0] PH_HEAD    = 2'd0;
   localparam logic [1:0] PH_ARG     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_HEAD  = 2'd1;
   localparam logic [1:0] EV_BYTE  = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TRUNC    = 3'd1;
   localparam logic [2:0] ERR_RESERVED = 3'd2;
   localparam logic [2:0] ERR_TAG      = 3'd3;
   localparam logic [2:0] ERR_SIMPLE   = 3'd4;
   localparam logic [2:0] ERR_TRAILING = 3'd5;
   localparam logic [2:0] ERR_DEEP     = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WORK = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic send;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic item_closes;
   } status_type;

endpackage

FILE: sv/scbor_ctrl.sv
// Controller for the CBOR parser: input capture, pop cascade sequencing, result handoff.
// Depends on scbor_pkg.
`timescale 1ns / 1ps
module scbor_ctrl import scbor_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   // A result stays in the output register until taken; a new byte is loaded
   // in the same cycle the old result leaves.
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_SEND && rsp_ready);
   assign rsp_valid = (state_ff == ST_SEND);

   always_comb begin
      cmd.load = req_valid && req_ready;
      cmd.step = (state_ff == ST_WORK);
      cmd.send = (state_ff == ST_WORK) && !status.item_closes;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.load) state_in = ST_WORK;
         ST_WORK: if (!status.item_closes) state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_ready) state_in = cmd.load ? ST_WORK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

FILE: sv/scbor_dp.sv
// Datapath for the CBOR parser: head decode, argument accumulation, nesting stack.
// Depends on scbor_pkg.
`timescale 1ns / 1ps
module scbor_dp import scbor_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_message,
   output logic [1:0]        rsp_event_kind,
   output logic [2:0]        rsp_major_type,
   output logic [63:0]       rsp_argument_value,
   output logic [7:0]        rsp_payload_byte,
   output logic [4:0]        rsp_nest_level,
   output logic              rsp_message_done,
   output logic              rsp_message_ok,
   output logic [2:0]        rsp_error_code
);
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        pmaj_ff, pmaj_in;
   logic [3:0]        abytes_ff, abytes_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       pleft_ff, pleft_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic              root_ff, root_in;
   logic [2:0]        err_ff, err_in;
   // Pending completion walking up the stack, one level per cycle.
   logic              closing_ff, closing_in;

   logic [7:0]        byte_ff;
   logic              last_ff;
   logic [4:0]        level_ff;

   logic [63:0] items_mem [MaxDepth];
   logic        ismap_mem [MaxDepth];
   logic        awaits_mem [MaxDepth];

   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  maj_ff, maj_in;
   logic [63:0] arg_ff, arg_in;
   logic [7:0]  pay_ff, pay_in;

   logic [LevelW-1:0] top;
   logic [63:0] top_items;
   logic        top_map, top_aw;
   logic        wr_en;
   logic [LevelW-1:0] wr_idx;
   logic [63:0] wr_items;
   logic        wr_map, wr_aw;

   logic [2:0] m;
   logic [4:0] info;
   logic [63:0] hd_arg;
   logic [2:0]  hd_maj;
   logic        hd_fire;
   logic [2:0]  err_now;
   logic        done_item;
   logic [2:0]  code;

   assign top = LevelW'(depth_ff - DepthW'(1));
   assign top_items = items_mem[top];
   assign top_map = ismap_mem[top];
   assign top_aw = awaits_mem[top];
   assign m = byte_ff[7:5];
   assign info = byte_ff[4:0];

   always_comb begin
      phase_in = phase_ff; pmaj_in = pmaj_ff; abytes_in = abytes_ff;
      acc_in = acc_ff; pleft_in = pleft_ff; depth_in = depth_ff;
      root_in = root_ff; err_in = err_ff; closing_in = 1'b0;
      kind_in = kind_ff; maj_in = maj_ff; arg_in = arg_ff; pay_in = pay_ff;
      wr_en = 1'b0; wr_idx = LevelW'(depth_ff); wr_items = 64'd0;
      wr_map = 1'b0; wr_aw = 1'b0;
      hd_fire = 1'b0; hd_maj = 3'd0; hd_arg = 64'd0; err_now = ERR_NONE;
      done_item = 1'b0;
      if (cmd.step && closing_ff) begin
         // Continue the pop cascade on the current top level.
         done_item = 1'b1;
      end else if (cmd.step) begin
         kind_in = EV_NONE; maj_in = 3'd0; arg_in = 64'd0; pay_in = 8'd0;
         if (err_ff == ERR_NONE) begin
            if (root_ff) begin
               err_now = ERR_TRAILING;
            end else if (phase_ff == PH_PAYLOAD) begin
               kind_in = EV_BYTE;
               pay_in = byte_ff;
               pleft_in = pleft_ff - 64'd1;
               if (pleft_ff == 64'd1) begin
                  phase_in = PH_HEAD;
                  done_item = 1'b1;
               end
            end else if (phase_ff == PH_ARG) begin
               acc_in = {acc_ff[55:0], byte_ff};
               abytes_in = abytes_ff - 4'd1;
               if (abytes_ff == 4'd1) begin
                  hd_fire = 1'b1; hd_maj = pmaj_ff; hd_arg = acc_in;
               end
            end else begin
               if (m == 3'd6) err_now = ERR_TAG;
               else if (info >= 5'd28) err_now = ERR_RESERVED;
               else if (m == 3'd7) begin
                  if (info == 5'd20 || info == 5'd21 || info == 5'd22) begin
                     hd_fire = 1'b1; hd_maj = m; hd_arg = {59'd0, info};
                  end else err_now = ERR_SIMPLE;
               end else if (info < 5'd24) begin
                  hd_fire = 1'b1; hd_maj = m; hd_arg = {59'd0, info};
               end else begin
                  pmaj_in = m;
                  acc_in = 64'd0;
                  abytes_in = 4'd1 << info[1:0];
                  phase_in = PH_ARG;
               end
            end
            if (hd_fire) begin
               phase_in = PH_HEAD;
               if (hd_maj == 3'd2 || hd_maj == 3'd3) begin
                  if (hd_arg != 64'd0) begin
                     pleft_in = hd_arg;
                     phase_in = PH_PAYLOAD;
                  end else done_item = 1'b1;
               end else if (hd_maj == 3'd4 || hd_maj == 3'd5) begin
                  if (hd_arg == 64'd0) done_item = 1'b1;
                  else if (depth_ff >= DepthW'(MaxDepth)) err_now = ERR_DEEP;
                  else begin
                     wr_en = 1'b1; wr_idx = LevelW'(depth_ff);
                     wr_items = hd_arg; wr_map = (hd_maj == 3'd5); wr_aw = 1'b0;
                     depth_in = depth_ff + DepthW'(1);
                  end
               end else done_item = 1'b1;
               if (err_now == ERR_NONE) begin
                  kind_in = EV_HEAD; maj_in = hd_maj; arg_in = hd_arg;
               end
            end
            if (err_now != ERR_NONE) begin
               err_in = err_now;
               kind_in = EV_ERROR; maj_in = 3'd0; arg_in = 64'd0; pay_in = 8'd0;
               done_item = 1'b0;
            end
         end
      end
      if (done_item) begin
         if (depth_ff == DepthW'(0)) root_in = 1'b1;
         else begin
            wr_en = 1'b1; wr_idx = top; wr_map = top_map; wr_items = top_items;
            if (top_map && !top_aw) wr_aw = 1'b1;
            else begin
               wr_aw = 1'b0;
               wr_items = top_items - 64'd1;
               if (top_items == 64'd1) begin
                  depth_in = depth_ff - DepthW'(1);
                  closing_in = 1'b1;
               end
            end
         end
      end
   end

   assign status.item_closes = closing_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         items_mem[wr_idx] <= wr_items;
         ismap_mem[wr_idx] <= wr_map;
         awaits_mem[wr_idx] <= wr_aw;
      end
      if (cmd.load) begin
         byte_ff <= req_data_byte;
         last_ff <= req_end_of_message;
         level_ff <= 5'(depth_ff);
      end
      acc_ff <= acc_in;
      pleft_ff <= pleft_in;
      kind_ff <= kind_in;
      maj_ff <= maj_in;
      arg_ff <= arg_in;
      pay_ff <= pay_in;
   end

   // On the last byte, state returns to reset once the result is formed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD; pmaj_ff <= 3'd0; abytes_ff <= 4'd0;
         depth_ff <= '0; root_ff <= 1'b0; err_ff <= ERR_NONE; closing_ff <= 1'b0;
      end else if (cmd.send && last_ff) begin
         phase_ff <= PH_HEAD; pmaj_ff <= 3'd0; abytes_ff <= 4'd0;
         depth_ff <= '0; root_ff <= 1'b0; err_ff <= ERR_NONE; closing_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; pmaj_ff <= pmaj_in; abytes_ff <= abytes_in;
         depth_ff <= depth_in; root_ff <= root_in; err_ff <= err_in;
         closing_ff <= closing_in;
      end
   end

   // Verdict registers are captured as the result enters the output register.
   logic       done_ff, ok_ff;
   logic [2:0] code_ff;
   always_comb begin
      code = err_in;
      if (last_ff && code == ERR_NONE && !root_in) code = ERR_TRUNC;
   end
   always_ff @(posedge clock) begin
      if (cmd.send) begin
         done_ff <= last_ff;
         ok_ff <= last_ff && (code == ERR_NONE);
         code_ff <= code;
      end
   end

   assign rsp_event_kind = kind_ff;
   assign rsp_major_type = maj_ff;
   assign rsp_argument_value = arg_ff;
   assign rsp_payload_byte = pay_ff;
   assign rsp_nest_level = level_ff;
   assign rsp_message_done = done_ff;
   assign rsp_message_ok = ok_ff;
   assign rsp_error_code = code_ff;
endmodule

FILE: sv/strict_cbor_stream_parser_top.sv
// Top level of the strict CBOR stream parser: controller plus datapath.
// Depends on scbor_pkg, scbor_ctrl, scbor_dp.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | data_byte, end_of_message
//   rsp     | out       | rsp_valid/rsp_ready  | event, head, payload, verdict
//
// A byte is worked on in ST_WORK, which stays active while container levels close
// with it (the pop cascade walks one stack level per cycle); then the result
// sits in the output register. The next byte is accepted as the result leaves.
// Reset is synchronous; no clearing pass is needed. A stalled rsp holds req.
`timescale 1ns / 1ps
module strict_cbor_stream_parser_top import scbor_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [2:0]  rsp_major_type,
   output logic [63:0] rsp_argument_value,
   output logic [7:0]  rsp_payload_byte,
   output logic [4:0]  rsp_nest_level,
   output logic        rsp_message_done,
   output logic        rsp_message_ok,
   output logic [2:0]  rsp_error_code
);
   cmd_type    cmd;
   status_type status;

   scbor_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   scbor_dp u_dp (
      .clock, .reset, .cmd, .status, .req_data_byte, .req_end_of_message,
      .rsp_event_kind, .rsp_major_type, .rsp_argument_value, .rsp_payload_byte,
      .rsp_nest_level, .rsp_message_done, .rsp_message_ok, .rsp_error_code
   );

`ifndef SYNTH
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_ok |-> rsp_message_done && rsp_error_code == ERR_NONE)
      else $error("message_ok with error");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_ready)
      else $error("byte accepted while working");
   a_head_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_HEAD |-> rsp_major_type == 3'd0)
      else $error("major type without head");
`endif
endmodule
